// File: rtl/imap_i2e_pkg.sv
// shared types, character codes and calendar tables of the date-to-epoch converter
package imap_i2e_pkg;

    // parse phase of the incoming date string
    typedef enum logic [3:0] {
        PH_LEAD = 4'd0,
        PH_DAY  = 4'd1,
        PH_MON  = 4'd2,
        PH_YEAR = 4'd3,
        PH_HOUR = 4'd4,
        PH_MIN  = 4'd5,
        PH_SEC  = 4'd6,
        PH_SIGN = 4'd7,
        PH_ZONE = 4'd8,
        PH_TAIL = 4'd9
    } t_phase;

    // controller states
    typedef enum logic [2:0] {
        ST_PARSE  = 3'd0,
        ST_YEAR   = 3'd1,
        ST_DIV100 = 3'd2,
        ST_DIV400 = 3'd3,
        ST_DAYS   = 3'd4,
        ST_SCALE  = 3'd5,
        ST_DONE   = 3'd6
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic take;     // a character transaction is accepted
        logic year;     // adjusted year, day-of-year offset, status
        logic div100;   // year / 100, time of day
        logic div400;   // year / 400, zone offset
        logic days;     // day count since the epoch
        logic scale;    // days to seconds
        logic finish;   // load the result and clear the parser
    } t_cmd;

    // ascii codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // month index when the name matches nothing
    localparam logic [3:0] MONTH_NONE = 4'd12;

    // field digit limits
    localparam logic [2:0] DIGITS_YEAR  = 3'd4;
    localparam logic [2:0] DIGITS_SHORT = 3'd2;
    localparam logic [2:0] DIGITS_ZONE  = 3'd4;

    // calendar constants
    localparam logic [13:0] YEAR_SHIFT   = 14'd400;     // keeps the year positive
    localparam logic [24:0] RECIP_25     = 25'd5243;    // ceil(2^17 / 25)
    localparam logic [23:0] DAYS_YEAR    = 24'd365;
    localparam logic [23:0] DAY_BIAS     = 24'd865566;  // epoch offset, shift era, day one
    localparam logic [39:0] SECS_DAY     = 40'd86400;
    localparam logic [18:0] SECS_HOUR    = 19'd3600;
    localparam logic [18:0] SECS_MINUTE  = 19'd60;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        "jan", "feb", "mar", "apr", "may", "jun",
        "jul", "aug", "sep", "oct", "nov", "dec"
    };

    // lower-case an ascii letter
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

    // month index 0..11 from three characters, first in the high byte, or MONTH_NONE
    function automatic logic [3:0] month_lookup(input logic [23:0] chars);
        logic [23:0] folded;
        logic [3:0]  idx;
        folded = {fold_case(chars[23:16]), fold_case(chars[15:8]), fold_case(chars[7:0])};
        idx    = MONTH_NONE;
        for (int m = 0; m < 12; m++) begin
            if (folded == MONTH_NAMES[m]) begin
                idx = 4'(m);
            end
        end
        return idx;
    endfunction

    // days from march 1 to the first of the month, march-based year
    function automatic logic [8:0] month_offset(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd0:    r = 9'd306;
            4'd1:    r = 9'd337;
            4'd2:    r = 9'd0;
            4'd3:    r = 9'd31;
            4'd4:    r = 9'd61;
            4'd5:    r = 9'd92;
            4'd6:    r = 9'd122;
            4'd7:    r = 9'd153;
            4'd8:    r = 9'd184;
            4'd9:    r = 9'd214;
            4'd10:   r = 9'd245;
            4'd11:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/imap_internaldate_to_epoch.sv
// top level: date string characters in, seconds since 1970 out
// throughput: one character per cycle; after the last character the input stalls
//   for the arithmetic sequence plus any wait for the output register to free
// the arithmetic sequence is the calendar steps: year, two divides, day count, scaling
// reset: synchronous, active low; clears the parser, controller and output valid
module imap_internaldate_to_epoch
    import imap_i2e_pkg::*;
#(
    parameter int MAX_CHARS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [38:0] epoch_seconds (signed), [39] zero
    output logic        o_m_axis_tuser    // [0] valid_res
);

    t_cmd        cmd;
    logic        out_free;
    logic [38:0] out_secs;

    imap_i2e_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_last     (i_s_axis_tlast),
        .i_out_free (out_free),
        .o_ready    (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    imap_i2e_dp #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_ch        (i_s_axis_tdata),
        .i_m_ready   (i_m_axis_tready),
        .o_out_free  (out_free),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_flag  (o_m_axis_tuser),
        .o_out_secs  (out_secs)
    );

    assign o_m_axis_tdata = {1'b0, out_secs};

endmodule

// File: rtl/imap_i2e_ctrl.sv
// controller: character intake and sequencing of the date arithmetic
module imap_i2e_ctrl
    import imap_i2e_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last,
    input  logic i_out_free,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_PARSE: begin
                if (i_valid && i_last) begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR:   n_state = ST_DIV100;
            ST_DIV100: n_state = ST_DIV400;
            ST_DIV400: n_state = ST_DAYS;
            ST_DAYS:   n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_PARSE;
                end
            end
            default:   n_state = ST_PARSE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_PARSE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            ST_YEAR:   o_cmd.year   = 1'b1;
            ST_DIV100: o_cmd.div100 = 1'b1;
            ST_DIV400: o_cmd.div400 = 1'b1;
            ST_DAYS:   o_cmd.days   = 1'b1;
            ST_SCALE:  o_cmd.scale  = 1'b1;
            ST_DONE:   o_cmd.finish = i_out_free;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/imap_i2e_dp.sv
// datapath: character parser, calendar arithmetic and result register
module imap_i2e_dp
    import imap_i2e_pkg::*;
#(
    parameter int MAX_CHARS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_ch,
    input  logic        i_m_ready,
    output logic        o_out_free,
    output logic        o_out_valid,
    output logic        o_out_flag,
    output logic [38:0] o_out_secs
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    // parser state
    t_phase      r_phase,  n_phase;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]  r_fdig,   n_fdig;
    logic [6:0]  r_day,    n_day;
    logic [23:0] r_mon,    n_mon;
    logic [13:0] r_year,   n_year;
    logic [6:0]  r_hour,   n_hour;
    logic [6:0]  r_min,    n_min;
    logic [6:0]  r_sec,    n_sec;
    logic        r_zneg,   n_zneg;
    logic [6:0]  r_zhour,  n_zhour;
    logic [6:0]  r_zmin,   n_zmin;
    logic        r_err,    n_err;

    // arithmetic registers
    logic        r_ok;
    logic [13:0] r_ybig;
    logic [8:0]  r_doy;
    logic [7:0]  r_q100;
    logic [4:0]  r_q400;
    logic [18:0] r_hms;
    logic [18:0] r_zone;
    logic [23:0] r_days;
    logic [39:0] r_tsec;

    // result register
    logic        r_out_valid;
    logic        r_out_flag;
    logic [38:0] r_out_secs;

    // parse helpers
    t_phase      eff_phase;
    logic        is_dig;
    logic [3:0]  dig;
    logic [13:0] f_val;
    logic [13:0] f_new;
    logic [2:0]  f_max;
    logic [7:0]  f_delim;
    t_phase      f_next;

    // arithmetic helpers
    logic [3:0]  mon_idx;
    logic [24:0] q100_prod;
    logic [22:0] q400_prod;
    logic [23:0] days_sum;
    logic [39:0] sec_sum;

    assign is_dig    = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign dig       = 4'(i_ch - CH_ZERO);
    assign eff_phase = (r_phase == PH_LEAD && i_ch != CH_SPACE) ? PH_DAY : r_phase;

    // field being filled by the current character
    always_comb begin
        f_val   = '0;
        f_max   = DIGITS_SHORT;
        f_delim = CH_COLON;
        f_next  = PH_TAIL;
        case (eff_phase)
            PH_DAY: begin
                f_val   = 14'(r_day);
                f_delim = CH_DASH;
                f_next  = PH_MON;
            end
            PH_YEAR: begin
                f_val   = r_year;
                f_max   = DIGITS_YEAR;
                f_delim = CH_SPACE;
                f_next  = PH_HOUR;
            end
            PH_HOUR: begin
                f_val   = 14'(r_hour);
                f_next  = PH_MIN;
            end
            PH_MIN: begin
                f_val   = 14'(r_min);
                f_next  = PH_SEC;
            end
            PH_SEC: begin
                f_val   = 14'(r_sec);
                f_delim = CH_SPACE;
                f_next  = PH_SIGN;
            end
            default: begin
                f_val = '0;
            end
        endcase
        f_new = 14'(18'(f_val) * 18'd10 + 18'(dig));
    end

    // parser next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_fdig  = r_fdig;
        n_day   = r_day;
        n_mon   = r_mon;
        n_year  = r_year;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_zneg  = r_zneg;
        n_zhour = r_zhour;
        n_zmin  = r_zmin;
        n_err   = r_err;
        if (i_cmd.finish) begin
            n_phase = PH_LEAD;
            n_count = '0;
            n_fdig  = '0;
            n_day   = '0;
            n_mon   = '0;
            n_year  = '0;
            n_hour  = '0;
            n_min   = '0;
            n_sec   = '0;
            n_zneg  = 1'b0;
            n_zhour = '0;
            n_zmin  = '0;
            n_err   = 1'b0;
        end else if (i_cmd.take && r_count < CW'(MAX_CHARS)) begin
            n_count = r_count + 1'b1;
            if (!r_err) begin
                case (eff_phase)
                    PH_DAY, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC: begin
                        n_phase = eff_phase;
                        if (is_dig) begin
                            if (r_fdig >= f_max) begin
                                n_err = 1'b1;
                            end else begin
                                n_fdig = r_fdig + 1'b1;
                                case (eff_phase)
                                    PH_DAY:  n_day  = f_new[6:0];
                                    PH_YEAR: n_year = f_new;
                                    PH_HOUR: n_hour = f_new[6:0];
                                    PH_MIN:  n_min  = f_new[6:0];
                                    PH_SEC:  n_sec  = f_new[6:0];
                                    default: n_err  = r_err;
                                endcase
                            end
                        end else if (i_ch == f_delim && r_fdig != '0) begin
                            n_phase = f_next;
                            n_fdig  = '0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_MON: begin
                        if (r_fdig < 3'd3) begin
                            n_mon  = {r_mon[15:0], i_ch};
                            n_fdig = r_fdig + 1'b1;
                        end else if (i_ch == CH_DASH && month_lookup(r_mon) != MONTH_NONE) begin
                            n_phase = PH_YEAR;
                            n_fdig  = '0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_SIGN: begin
                        if (i_ch == CH_PLUS || i_ch == CH_DASH) begin
                            n_zneg  = (i_ch == CH_DASH);
                            n_phase = PH_ZONE;
                            n_fdig  = '0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_ZONE: begin
                        if (!is_dig) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_fdig < 3'd2) begin
                                n_zhour = 7'(8'(r_zhour) * 8'd10 + 8'(dig));
                            end else begin
                                n_zmin = 7'(8'(r_zmin) * 8'd10 + 8'(dig));
                            end
                            if (r_fdig == DIGITS_ZONE - 3'd1) begin
                                n_phase = PH_TAIL;
                                n_fdig  = '0;
                            end else begin
                                n_fdig = r_fdig + 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_count <= '0;
            r_fdig  <= '0;
            r_day   <= '0;
            r_mon   <= '0;
            r_year  <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_zneg  <= 1'b0;
            r_zhour <= '0;
            r_zmin  <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_fdig  <= n_fdig;
            r_day   <= n_day;
            r_mon   <= n_mon;
            r_year  <= n_year;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_zneg  <= n_zneg;
            r_zhour <= n_zhour;
            r_zmin  <= n_zmin;
            r_err   <= n_err;
        end
    end

    // calendar arithmetic, one step per command
    assign mon_idx   = month_lookup(r_mon);
    assign q100_prod = 25'(r_ybig[13:2]) * RECIP_25;
    assign q400_prod = 23'(25'(r_ybig[13:4]) * RECIP_25);
    assign days_sum  = 24'(r_ybig) * DAYS_YEAR + 24'(r_ybig[13:2]) - 24'(r_q100)
                     + 24'(r_q400) + 24'(r_doy) + 24'(r_day) - DAY_BIAS;
    assign sec_sum   = r_zneg ? r_tsec + 40'(r_hms) + 40'(r_zone)
                              : r_tsec + 40'(r_hms) - 40'(r_zone);

    always_ff @(posedge i_clk) begin
        if (i_cmd.year) begin
            r_ok   <= !r_err && (r_phase == PH_TAIL);
            r_ybig <= r_year + YEAR_SHIFT - ((mon_idx <= 4'd1) ? 14'd1 : 14'd0);
            r_doy  <= month_offset(mon_idx);
        end
        if (i_cmd.div100) begin
            r_q100 <= q100_prod[24:17];
            r_hms  <= 19'(19'(r_hour) * SECS_HOUR + 19'(r_min) * SECS_MINUTE + 19'(r_sec));
        end
        if (i_cmd.div400) begin
            r_q400 <= q400_prod[21:17];
            r_zone <= 19'(19'(r_zhour) * SECS_HOUR + 19'(r_zmin) * SECS_MINUTE);
        end
        if (i_cmd.days) begin
            r_days <= days_sum;
        end
        if (i_cmd.scale) begin
            r_tsec <= {{16{r_days[23]}}, r_days} * SECS_DAY;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_flag <= r_ok;
            r_out_secs <= r_ok ? sec_sum[38:0] : '0;
        end
    end

    assign o_out_free  = !r_out_valid || i_m_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_flag  = r_out_flag;
    assign o_out_secs  = r_out_secs;

endmodule
